>>> hw/rtl/srq_pkg.sv
package srq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    // field widths
    localparam int KIND_W  = 2;
    localparam int WORD_W  = 32;
    localparam int INDEX_W = 5;
    localparam int COUNT_W = 5;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(16);
    localparam logic [INDEX_W-1:0] NO_INDEX  = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ  = 2'd0,
        KIND_DEQ  = 2'd1,
        KIND_SRCH = 2'd2,
        KIND_CLR  = 2'd3
    } t_kind;

    // per-cell control for one cycle
    typedef struct packed {
        logic load;   // take the incoming word
        logic shift;  // take the neighbor's word
        logic cmp;    // compare against the search key
    } t_cell_ctl;

endpackage

>>> hw/rtl/srq_in_if.sv
interface srq_in_if;
    logic                              valid;
    logic                              ready;
    srq_pkg::t_kind                    kind;
    logic signed [srq_pkg::WORD_W-1:0] value;

    modport source (output valid, kind, value, input ready);
    modport sink   (input valid, kind, value, output ready);
endinterface

>>> hw/rtl/srq_out_if.sv
interface srq_out_if;
    logic                               valid;
    logic                               ready;
    logic                               ok;
    logic signed [srq_pkg::WORD_W-1:0]  word;
    logic signed [srq_pkg::INDEX_W-1:0] found_index;
    logic [srq_pkg::COUNT_W-1:0]        count;

    modport source (output valid, ok, word, found_index, count, input ready);
    modport sink   (input valid, ok, word, found_index, count, output ready);
endinterface

>>> hw/rtl/srq_cell.sv
module srq_cell (
    input  logic                       i_clk,
    input  srq_pkg::t_cell_ctl         i_ctl,
    input  logic [srq_pkg::WORD_W-1:0] i_value,
    input  logic [srq_pkg::WORD_W-1:0] i_next,
    output logic [srq_pkg::WORD_W-1:0] o_data,
    output logic                       o_match
);

    logic [srq_pkg::WORD_W-1:0] r_data;
    logic                       r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_data <= i_value;
        end else if (i_ctl.shift) begin
            r_data <= i_next;
        end
        r_match <= i_ctl.cmp && (r_data == i_value);
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

>>> hw/rtl/shift_register_queue_with_search.sv
// first-in first-out queue of signed 32-bit words kept in a row of DEPTH
// cells; each input word is an operation (enqueue, dequeue, search, clear)
// and gives exactly one result word with ok, the dequeued or head word, the
// search position (-1 when none) and the count after the operation.
// at acceptance the tail cell loads, every cell shifts toward the head or
// the occupied cells compare against the key in parallel; in the next
// cycle the lowest matching cell is picked and the result is registered.
// no operation is taken in the pick cycle; while a result is pending the
// output register lets the next one in only if that result is taken in
// the same cycle. capacity (reset 16) must be written through i_cfg_we /
// i_cfg_wdata only while the queue is idle; the block does not enforce it.
// values above DEPTH act as DEPTH and zero makes every enqueue fail.
module shift_register_queue_with_search #(
    parameter int DEPTH = srq_pkg::DEPTH_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    srq_in_if.sink                    i_in,
    srq_out_if.source                 o_out,
    input  logic                      i_cfg_we,
    input  logic [srq_pkg::CAP_W-1:0] i_cfg_wdata
);

    localparam int FW = $clog2(DEPTH + 1);            // fill count width
    localparam int IW = $clog2(DEPTH);                // cell index width
    localparam int CW = (FW > srq_pkg::CAP_W) ? FW : srq_pkg::CAP_W;
    localparam int XW = IW + srq_pkg::INDEX_W;        // index widening

    // control state
    logic [FW-1:0]             r_fill, n_fill;
    logic [srq_pkg::CAP_W-1:0] r_cap;
    logic                      r_busy;
    logic                      r_out_valid;

    // operation held for the pick cycle
    srq_pkg::t_kind              r_kind;
    logic                        r_ok, n_ok;
    logic [srq_pkg::WORD_W-1:0]  r_word, n_word;

    // result register
    logic                         r_o_ok;
    logic [srq_pkg::WORD_W-1:0]   r_o_word;
    logic [srq_pkg::INDEX_W-1:0]  r_o_index;
    logic [srq_pkg::COUNT_W-1:0]  r_o_count;

    logic                         w_accept;
    logic                         w_enq_ok;
    logic                         w_deq_ok;
    logic [CW-1:0]                w_fill_x;
    logic [CW-1:0]                w_cap_x;
    logic [srq_pkg::WORD_W-1:0]   w_head;
    logic [DEPTH-1:0]             w_match;
    logic [IW-1:0]                w_pick;
    logic [XW-1:0]                w_pick_x;
    logic [srq_pkg::WORD_W-1:0]   w_data [DEPTH];
    srq_pkg::t_cell_ctl           w_ctl  [DEPTH];

    // take a word when the pick cycle is over and the result slot frees up
    assign i_in.ready = !r_busy && (!r_out_valid || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;

    // room check against min(capacity, DEPTH)
    assign w_fill_x = CW'(r_fill);
    assign w_cap_x  = CW'(r_cap);
    assign w_enq_ok = (w_fill_x < CW'(DEPTH)) && (w_fill_x < w_cap_x);
    assign w_deq_ok = (r_fill != '0);
    assign w_head   = w_data[0];

    // the cell row
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [srq_pkg::WORD_W-1:0] w_next;

        // last cell has no neighbor behind it, it only ever empties
        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_data[g];
        end else begin : g_mid
            assign w_next = w_data[g+1];
        end

        // tail cell takes the enqueued word, all cells shift on dequeue,
        // only occupied cells take part in a search
        assign w_ctl[g].load  = w_accept && (i_in.kind == srq_pkg::KIND_ENQ)
                                && w_enq_ok && (r_fill == FW'(g));
        assign w_ctl[g].shift = w_accept && (i_in.kind == srq_pkg::KIND_DEQ)
                                && w_deq_ok;
        assign w_ctl[g].cmp   = w_accept && (i_in.kind == srq_pkg::KIND_SRCH)
                                && (FW'(g) < r_fill);

        srq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[g]),
            .i_value (i_in.value),
            .i_next  (w_next),
            .o_data  (w_data[g]),
            .o_match (w_match[g])
        );
    end

    // operation outcome known at acceptance
    always_comb begin
        n_fill = r_fill;
        n_ok   = 1'b0;
        n_word = '0;
        case (i_in.kind)
            srq_pkg::KIND_ENQ: begin
                n_ok = w_enq_ok;
                if (w_enq_ok) begin
                    n_fill = r_fill + FW'(1);
                end
                // head after the operation: new word if the queue was empty
                if (w_deq_ok) begin
                    n_word = w_head;
                end else if (w_enq_ok) begin
                    n_word = i_in.value;
                end
            end
            srq_pkg::KIND_DEQ: begin
                n_ok = w_deq_ok;
                if (w_deq_ok) begin
                    n_fill = r_fill - FW'(1);
                    n_word = w_head;
                end
            end
            srq_pkg::KIND_SRCH: begin
                // ok is settled in the pick cycle
                if (w_deq_ok) begin
                    n_word = w_head;
                end
            end
            default: begin
                // clear
                n_fill = '0;
                n_ok   = 1'b1;
            end
        endcase
    end

    // lowest matching cell
    always_comb begin
        w_pick = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_pick = IW'(i);
            end
        end
    end
    assign w_pick_x = XW'(w_pick);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_cap       <= srq_pkg::CAP_RESET;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_fill <= n_fill;
            end
            r_busy <= w_accept;
            if (r_busy) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_in.kind;
            r_ok   <= n_ok;
            r_word <= n_word;
        end
        if (r_busy) begin
            r_o_word  <= r_word;
            r_o_count <= w_fill_x[srq_pkg::COUNT_W-1:0];
            if (r_kind == srq_pkg::KIND_SRCH) begin
                r_o_ok    <= |w_match;
                r_o_index <= (|w_match) ? w_pick_x[srq_pkg::INDEX_W-1:0]
                                        : srq_pkg::NO_INDEX;
            end else begin
                r_o_ok    <= r_ok;
                r_o_index <= srq_pkg::NO_INDEX;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.ok          = r_o_ok;
    assign o_out.word        = r_o_word;
    assign o_out.found_index = r_o_index;
    assign o_out.count       = r_o_count;

endmodule

>>> tb/tb_shift_register_queue_with_search.sv
`timescale 1ns / 100ps
module tb_shift_register_queue_with_search;

    localparam int QDEPTH        = srq_pkg::DEPTH_DEFAULT;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int RECENT_KEEP   = 20;

    typedef logic signed [srq_pkg::WORD_W-1:0] t_word;

    typedef struct {
        srq_pkg::t_kind kind;
        t_word          value;
    } t_queue_op;

    typedef struct {
        logic                               ok;
        t_word                              word;
        logic signed [srq_pkg::INDEX_W-1:0] found_index;
        logic [srq_pkg::COUNT_W-1:0]        count;
    } t_queue_result;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_we    = 1'b0;
    logic [srq_pkg::CAP_W-1:0] i_cfg_wdata = '0;

    srq_in_if  in_if ();
    srq_out_if out_if ();

    shift_register_queue_with_search #(.DEPTH(QDEPTH)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // mirror of the queue contents, fill and capacity
    t_word mirror_cells [QDEPTH];
    int    mirror_fill = 0;
    int    mirror_cap  = int'(srq_pkg::CAP_RESET);

    t_queue_op     pending_ops [$];
    t_queue_result expected_results [$];
    t_word         recent_words [$];

    int  fail_count = 0;
    bit  no_idle    = 1'b0;
    int  hold_req   = 0;

    // driver state
    bit        drv_on  = 1'b0;
    int        drv_gap = 0;
    t_queue_op drv_op;

    // monitor state
    int rx_stall  = 0;
    int hold_seen = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // predicts one result and advances the mirror
    function automatic t_queue_result apply_op(t_queue_op op);
        t_queue_result r;
        int            limit;
        r.ok          = 1'b0;
        r.word        = '0;
        r.found_index = srq_pkg::NO_INDEX;
        limit = (mirror_cap > QDEPTH) ? QDEPTH : mirror_cap;
        case (op.kind)
            srq_pkg::KIND_ENQ: begin
                if (mirror_fill < limit) begin
                    mirror_cells[mirror_fill] = op.value;
                    mirror_fill++;
                    r.ok = 1'b1;
                end
                if (mirror_fill > 0) r.word = mirror_cells[0];
            end
            srq_pkg::KIND_DEQ: begin
                if (mirror_fill > 0) begin
                    r.word = mirror_cells[0];
                    for (int i = 1; i < mirror_fill; i++)
                        mirror_cells[i-1] = mirror_cells[i];
                    mirror_fill--;
                    r.ok = 1'b1;
                end
            end
            srq_pkg::KIND_SRCH: begin
                // lowest matching position wins
                for (int i = 0; i < mirror_fill; i++) begin
                    if (!r.ok && mirror_cells[i] == op.value) begin
                        r.found_index = srq_pkg::INDEX_W'(i);
                        r.ok          = 1'b1;
                    end
                end
                if (mirror_fill > 0) r.word = mirror_cells[0];
            end
            default: begin
                mirror_fill = 0;
                r.ok        = 1'b1;
            end
        endcase
        r.count = srq_pkg::COUNT_W'(mirror_fill);
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int p = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (p < 50) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_word rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return t_word'($urandom_range(0, 8)) - 4;
            3:       return $urandom_range(0, 1) ? t_word'(0) : t_word'(-1);
            default: return t_word'($urandom());
        endcase
    endfunction

    function automatic void push_op(srq_pkg::t_kind kind, t_word value);
        t_queue_op op;
        op.kind  = kind;
        op.value = value;
        pending_ops.push_back(op);
        if (kind == srq_pkg::KIND_ENQ) begin
            recent_words.push_back(value);
            if (recent_words.size() > RECENT_KEEP) void'(recent_words.pop_front());
        end
    endfunction

    // driver: offers pending words with random gaps, predicts on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.kind  <= srq_pkg::KIND_ENQ;
            in_if.value <= '0;
            drv_on  = 1'b0;
            drv_gap = 0;
        end else begin
            if (drv_on && in_if.ready) begin
                expected_results.push_back(apply_op(drv_op));
                drv_on  = 1'b0;
                drv_gap = pick_gap();
            end
            if (!drv_on) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                end else if (pending_ops.size() > 0) begin
                    drv_op = pending_ops.pop_front();
                    drv_on = 1'b1;
                    in_if.kind  <= drv_op.kind;
                    in_if.value <= drv_op.value;
                end
            end
            in_if.valid <= drv_on;
        end
    end

    // monitor: checks each result against the oldest prediction, stalls at random
    always @(posedge i_clk) begin
        t_queue_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_stall  = 0;
            hold_seen = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected, ok %0b word %0d",
                             $time, out_if.ok, out_if.word);
                    $display("%0t: index %0d count %0d",
                             $time, out_if.found_index, out_if.count);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_if.ok !== want.ok) begin
                        $display("%0t: ok mismatch, expected %0b actual %0b",
                                 $time, want.ok, out_if.ok);
                        fail_count++;
                    end
                    if (out_if.word !== want.word) begin
                        $display("%0t: word mismatch, expected %0d actual %0d",
                                 $time, want.word, out_if.word);
                        fail_count++;
                    end
                    if (out_if.found_index !== want.found_index) begin
                        $display("%0t: found_index mismatch, expected %0d actual %0d",
                                 $time, want.found_index, out_if.found_index);
                        fail_count++;
                    end
                    if (out_if.count !== want.count) begin
                        $display("%0t: count mismatch, expected %0d actual %0d",
                                 $time, want.count, out_if.count);
                        fail_count++;
                    end
                end
                rx_stall = pick_gap();
            end
            // long hold-off so the queue backs up into its input
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                rx_stall  = HOLD_CYCLES;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // waits until nothing is pending or in flight, then lets the block settle
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_ops.size() != 0 || drv_on || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_capacity(input int cap);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= srq_pkg::CAP_W'(cap);
        mirror_cap = cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // bursts that lean toward filling or draining so the fill sweeps its range
    task automatic queue_random(input int n);
        int    burst   = 0;
        bit    filling = 1'b1;
        int    p;
        t_word v;
        for (int i = 0; i < n; i++) begin
            if (burst == 0) begin
                burst   = $urandom_range(4, 24);
                filling = $urandom_range(0, 1);
            end
            burst--;
            p = $urandom_range(0, 99);
            if (p < 3) begin
                push_op(srq_pkg::KIND_CLR, t_word'($urandom()));
            end else if (p < 28) begin
                if (recent_words.size() > 0 && $urandom_range(0, 9) < 6)
                    v = recent_words[$urandom_range(0, recent_words.size() - 1)];
                else
                    v = rand_word();
                push_op(srq_pkg::KIND_SRCH, v);
            end else if (p < 28 + (filling ? 52 : 20)) begin
                push_op(srq_pkg::KIND_ENQ, rand_word());
            end else begin
                push_op(srq_pkg::KIND_DEQ, t_word'($urandom()));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty queue, extreme words, fill to the top, overflow, clear
        no_idle = 1'b1;
        push_op(srq_pkg::KIND_DEQ, 32'sh1234_5678);
        push_op(srq_pkg::KIND_SRCH, 32'sh0);
        push_op(srq_pkg::KIND_ENQ, 32'sh7fff_ffff);
        push_op(srq_pkg::KIND_ENQ, 32'sh8000_0000);
        push_op(srq_pkg::KIND_ENQ, 32'sh0);
        push_op(srq_pkg::KIND_ENQ, -32'sd1);
        push_op(srq_pkg::KIND_SRCH, -32'sd1);
        push_op(srq_pkg::KIND_SRCH, 32'sh8000_0000);
        push_op(srq_pkg::KIND_SRCH, 32'sh0bad_cafe);
        push_op(srq_pkg::KIND_ENQ, 32'sh5555_5555);
        push_op(srq_pkg::KIND_ENQ, 32'shaaaa_aaaa);
        push_op(srq_pkg::KIND_ENQ, -32'sd1);     // duplicate of a word already in the queue
        for (int i = 0; i < 7; i++) push_op(srq_pkg::KIND_ENQ, t_word'($urandom()));
        push_op(srq_pkg::KIND_ENQ, 32'sh0f0f_0f0f);
        push_op(srq_pkg::KIND_ENQ, 32'sh7fff_fff0);   // sixteenth entry, queue now full
        push_op(srq_pkg::KIND_ENQ, 32'sh1111_1111);   // rejected when full
        push_op(srq_pkg::KIND_SRCH, 32'sh7fff_fff0);
        push_op(srq_pkg::KIND_DEQ, 32'sh0);
        push_op(srq_pkg::KIND_CLR, 32'sh0);
        wait_idle();

        no_idle = 1'b0;
        queue_random(300);
        wait_idle();

        // smallest useful capacity
        write_capacity(1);
        queue_random(100);
        wait_idle();

        // capacity zero: every enqueue rejected
        write_capacity(0);
        queue_random(60);
        wait_idle();

        // capacity above depth behaves as depth
        write_capacity(31);
        no_idle = 1'b1;
        queue_random(80);
        wait_idle();
        no_idle = 1'b0;
        queue_random(170);
        wait_idle();

        write_capacity(5);
        queue_random(150);
        wait_idle();

        // capacity lowered under the current fill keeps the entries
        write_capacity(16);
        push_op(srq_pkg::KIND_CLR, 32'sh0);
        for (int i = 0; i < 10; i++) push_op(srq_pkg::KIND_ENQ, rand_word());
        wait_idle();
        write_capacity(3);
        push_op(srq_pkg::KIND_ENQ, 32'sh2222_2222);
        push_op(srq_pkg::KIND_SRCH, recent_words[recent_words.size() - 1]);
        for (int i = 0; i < 7; i++) push_op(srq_pkg::KIND_DEQ, 32'sh0);
        push_op(srq_pkg::KIND_ENQ, 32'sh3333_3333);
        push_op(srq_pkg::KIND_DEQ, 32'sh0);
        push_op(srq_pkg::KIND_ENQ, 32'sh4444_4444);
        wait_idle();

        // back to full size, receiver holds off while words keep coming
        write_capacity(16);
        hold_req++;
        queue_random(200);
        wait_idle();

        if (fail_count == 0) begin
            $display("PASS shift_register_queue_with_search");
        end else begin
            $display("FAIL shift_register_queue_with_search");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL shift_register_queue_with_search");
        $finish;
    end

endmodule
